FILE: hw/rtl/pf6kw_pkg.sv
// types and constants shared by the 6k+-1 wheel prime factorizer
// no dependencies; imported by the top level and the testbench
package pf6kw_pkg;

    // controller states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_FLUSH = 6'b010000,
        ST_EMPTY = 6'b100000
    } state_t;

    // which divisor is being stripped
    typedef enum logic [2:0] {
        STG_TWO    = 3'd0,
        STG_THREE  = 3'd1,
        STG_CHECK  = 3'd2,  // first try of i, also tests i*i <= rem
        STG_FIRST  = 3'd3,  // further tries of i
        STG_SECOND = 3'd4   // tries of i+2
    } stage_t;

    localparam int FIRST_PRIME     = 2;
    localparam int LAST_SMALL      = 3;
    localparam int FIRST_CANDIDATE = 5;
    localparam int SECOND_OFFSET   = 2;
    localparam int WHEEL_STEP      = 6;

endpackage

FILE: hw/rtl/prime_factorizer_6k_wheel_top.sv
// prime factorizer top level: control sequencer and bit-serial divider
// depends on pf6kw_pkg
//
// usage:
//   s_axis carries one request: tdata holds number (VALUE_WIDTH bits, two's
//   complement), zero padded to whole bytes. m_axis returns the prime factors
//   in ascending order, one per result: tdata holds factor (VALUE_WIDTH-1
//   bits), tlast marks the final result of a request, tuser is the empty flag
//   (set, with factor 0, when the number is 1 or less).
//   one request is worked on at a time; s_axis_tready is high only when idle.
//   every trial division runs on a restoring divider that produces one
//   quotient bit per cycle; a trial is a load, one shift step for each
//   bit of the dividend, and an evaluate of the remainder.
//   the most recent factor is held back one step so that tlast can be set;
//   the output register holds a result until it is taken, and the sequencer
//   waits whenever a new result finds that register still full.
//   reset (asynchronous, active low) returns to idle with no result pending.
module prime_factorizer_6k_wheel_top
    import pf6kw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [VALUE_WIDTH-1:0] number
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [VALUE_WIDTH-2:0] factor
    output logic [((VALUE_WIDTH + 6) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                                   m_axis_tlast,
    // [0] empty_res
    output logic                                   m_axis_tuser
);

    localparam int N     = VALUE_WIDTH - 1;
    localparam int DW    = (N + 1) / 2 + 1;
    localparam int CW    = $clog2(N);
    localparam int OUT_W = ((VALUE_WIDTH + 6) / 8) * 8;

    state_t          state_reg, state_next;
    stage_t          stage_reg, stage_next;
    logic [N-1:0]    rem_reg, rem_next;
    logic [DW-1:0]   base_reg, base_next;
    logic [DW-1:0]   div_reg, div_next;
    logic [DW-1:0]   pr_reg, pr_next;
    logic [N-1:0]    qs_reg, qs_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [N-1:0]    pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    logic [N-1:0]    out_factor_reg, out_factor_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;

    logic            in_accept;
    logic            in_empty;
    logic            out_free;
    logic            out_load;
    logic [DW:0]     pr_shift;
    logic [DW:0]     pr_diff;
    logic [N-1:0]    div_wide;
    logic            past_root;
    logic            r_zero;
    logic            has_factor;
    logic [N-1:0]    factor_val;
    logic            blocked;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_empty      = s_axis_tdata[VALUE_WIDTH-1] || (s_axis_tdata[N-1:1] == '0);
    assign out_free      = !out_valid_reg || m_axis_tready;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign pr_shift = {pr_reg, qs_reg[N-1]};
    assign pr_diff  = pr_shift - {1'b0, div_reg};

    assign div_wide   = N'(div_reg);
    assign r_zero     = (pr_reg == '0);
    assign past_root  = (stage_reg == STG_CHECK) && (div_wide > qs_reg);
    assign has_factor = past_root ? (rem_reg > N'(LAST_SMALL)) : r_zero;
    assign factor_val = past_root ? rem_reg : div_wide;
    assign blocked    = has_factor && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        stage_next      = stage_reg;
        rem_next        = rem_reg;
        base_next       = base_reg;
        div_next        = div_reg;
        pr_next         = pr_reg;
        qs_next         = qs_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_factor_next = out_factor_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_empty)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        rem_next   = s_axis_tdata[N-1:0];
                        stage_next = STG_TWO;
                        div_next   = DW'(FIRST_PRIME);
                        base_next  = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                pr_next    = '0;
                qs_next    = rem_reg;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!pr_diff[DW])
                begin
                    pr_next = pr_diff[DW-1:0];
                end
                else
                begin
                    pr_next = pr_shift[DW-1:0];
                end
                qs_next  = {qs_reg[N-2:0], !pr_diff[DW]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(N - 1))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!blocked)
                begin
                    if (has_factor)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load        = 1'b1;
                            out_factor_next = pend_reg;
                            out_last_next   = 1'b0;
                            out_empty_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = factor_val;
                    end
                    if (past_root)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else if (r_zero)
                    begin
                        rem_next   = qs_reg;
                        state_next = ST_START;
                        if (stage_reg == STG_CHECK)
                        begin
                            stage_next = STG_FIRST;
                        end
                    end
                    else
                    begin
                        state_next = ST_START;
                        case (stage_reg)
                            STG_TWO:
                            begin
                                stage_next = STG_THREE;
                                div_next   = DW'(LAST_SMALL);
                            end
                            STG_THREE:
                            begin
                                stage_next = STG_CHECK;
                                base_next  = DW'(FIRST_CANDIDATE);
                                div_next   = DW'(FIRST_CANDIDATE);
                            end
                            STG_CHECK, STG_FIRST:
                            begin
                                stage_next = STG_SECOND;
                                div_next   = base_reg + DW'(SECOND_OFFSET);
                            end
                            default:
                            begin
                                stage_next = STG_CHECK;
                                base_next  = base_reg + DW'(WHEEL_STEP);
                                div_next   = base_reg + DW'(WHEEL_STEP);
                            end
                        endcase
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_factor_next = pend_reg;
                    out_last_next   = 1'b1;
                    out_empty_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_factor_next = '0;
                    out_last_next   = 1'b1;
                    out_empty_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            stage_reg      <= STG_TWO;
            rem_reg        <= '0;
            base_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stage_reg      <= stage_next;
            rem_reg        <= rem_next;
            base_reg       <= base_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg        <= div_next;
        pr_reg         <= pr_next;
        qs_reg         <= qs_next;
        pend_reg       <= pend_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_factor_reg);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule

FILE: hw/rtl/pf6kw_checker.sv
// port-level checks for the prime factorizer, with the bind that attaches them
// depends on prime_factorizer_6k_wheel_top
module pf6kw_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic [((VALUE_WIDTH + 6) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   m_axis_tlast,
    input  logic                                   m_axis_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // the empty result is a single framed result with factor zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("empty result malformed");

    // every real factor is at least two
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[VALUE_WIDTH-2:1] != '0))
        else $error("factor below two");

    // one request at a time: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind prime_factorizer_6k_wheel_top pf6kw_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_pf6kw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/prime_factorizer_6k_wheel_top_tb.sv
`timescale 1ns / 1ps
// testbench for prime_factorizer_6k_wheel_top: directed rows, then random numbers
// checked against a trial-division predictor; depends on pf6kw_pkg and the top level
module prime_factorizer_6k_wheel_top_tb
    import pf6kw_pkg::*;
();

    localparam int          NUM_WIDTH   = 32;
    localparam int          FAC_WIDTH   = NUM_WIDTH - 1;
    localparam int          RESULT_CAP  = NUM_WIDTH - 2;
    localparam int          RAND_ITEMS  = 76;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          DRAIN_WAIT  = 200;
    localparam longint      CYCLE_LIMIT = 20_000_000;
    localparam longint      NUM_MAX     = 64'h7FFF_FFFF;
    localparam logic [7:0]  STALL_PAT   = 8'b1011_0010;

    typedef struct packed {
        logic [FAC_WIDTH-1:0] factor;
        logic                 last;
        logic                 empty_res;
    } factor_res_t;

    typedef struct {
        logic [NUM_WIDTH-1:0] number;
        bit                   typed;
        logic [FAC_WIDTH-1:0] factor;
        logic                 empty_res;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    // expected factors, oldest first
    factor_res_t          factor_q[$];
    stim_row_t            stim_rows[$];

    // predictor state
    longint unsigned      pred_rem;
    logic [16:0]          pred_trial_div;
    logic [FAC_WIDTH-1:0] staged_fac [0:RESULT_CAP-1];
    int                   staged_cnt;

    int unsigned prime_list [0:19] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29,
                                       31, 37, 41, 43, 47, 53, 101, 251, 509, 1021};

    int          error_cnt = 0;
    int          burst_left = 0;
    int          sent_cnt = 0;
    int          result_cnt = 0;
    int          empty_cnt = 0;
    int          run_len = 0;
    int          longest_run = 0;
    int          hold_reqs = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          rx_cycle = 0;
    longint      cycle_cnt = 0;
    factor_res_t got_r;
    factor_res_t exp_r;

    prime_factorizer_6k_wheel_top #(
        .VALUE_WIDTH(NUM_WIDTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // divide out every copy of d, staging each factor
    function automatic void strip_divisor(longint unsigned d);
        while (d > 1 && pred_rem % d == 0 && staged_cnt < RESULT_CAP)
        begin
            staged_fac[staged_cnt] = d[FAC_WIDTH-1:0];
            staged_cnt++;
            pred_rem = pred_rem / d;
        end
    endfunction

    function automatic void predict_factors(logic [NUM_WIDTH-1:0] value);
        longint unsigned cand;
        factor_res_t     r;
        if (value[NUM_WIDTH-1] || value <= 1)
        begin
            r.factor    = '0;
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            factor_q.insert(factor_q.size(), r);
            pred_rem       = 0;
            pred_trial_div = '0;
            return;
        end
        pred_rem   = value;
        staged_cnt = 0;
        strip_divisor(FIRST_PRIME);
        strip_divisor(LAST_SMALL);
        for (cand = FIRST_CANDIDATE; cand <= pred_rem / cand; cand += WHEEL_STEP)
        begin
            pred_trial_div = cand[16:0];
            strip_divisor(cand);
            strip_divisor(cand + SECOND_OFFSET);
        end
        // whatever survives the wheel is itself prime
        if (pred_rem > LAST_SMALL && staged_cnt < RESULT_CAP)
        begin
            staged_fac[staged_cnt] = pred_rem[FAC_WIDTH-1:0];
            staged_cnt++;
            pred_rem = 1;
        end
        if (staged_cnt == 0)
        begin
            r.factor    = '0;
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            factor_q.insert(factor_q.size(), r);
        end
        for (int k = 0; k < staged_cnt; k++)
        begin
            r.factor    = staged_fac[k];
            r.last      = (k == staged_cnt - 1);
            r.empty_res = 1'b0;
            factor_q.insert(factor_q.size(), r);
        end
    endfunction

    // called and returns at a falling edge
    task automatic send_number(input logic [NUM_WIDTH-1:0] value, input bit typed,
                               input logic [FAC_WIDTH-1:0] exp_factor,
                               input logic exp_empty);
        int          gap;
        factor_res_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
        begin
            r.factor    = exp_factor;
            r.last      = 1'b1;
            r.empty_res = exp_empty;
            factor_q.insert(factor_q.size(), r);
        end
        else
            predict_factors(value);
        sent_cnt++;
        burst_left--;
        @(negedge clk);
    endtask

    // receiver: rotating stall pattern, plus long hold-offs on request
    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left == 0 && hold_served != hold_reqs)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= STALL_PAT[3'(rx_cycle % 8)];
                2: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r.factor    = m_axis_tdata[FAC_WIDTH-1:0];
            got_r.last      = m_axis_tlast;
            got_r.empty_res = m_axis_tuser;
            if (factor_q.size() == 0)
            begin
                $error("unexpected result: factor %0d last %0b empty_res %0b",
                       got_r.factor, got_r.last, got_r.empty_res);
                error_cnt++;
            end
            else
            begin
                exp_r = factor_q.pop_front();
                if (got_r.factor !== exp_r.factor)
                begin
                    $error("factor: expected %0d, got %0d", exp_r.factor, got_r.factor);
                    error_cnt++;
                end
                if (got_r.last !== exp_r.last)
                begin
                    $error("last: expected %0b, got %0b", exp_r.last, got_r.last);
                    error_cnt++;
                end
                if (got_r.empty_res !== exp_r.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b",
                           exp_r.empty_res, got_r.empty_res);
                    error_cnt++;
                end
            end
            result_cnt++;
            run_len++;
            if (got_r.empty_res)
                empty_cnt++;
            if (got_r.last)
            begin
                if (run_len > longest_run)
                    longest_run = run_len;
                run_len = 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, factor_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [NUM_WIDTH-1:0] value;
        longint               prod;
        longint               p;
        int                   nf;
        int                   rep;
        int                   pick;
        int                   directed_cnt;

        // numbers of 1 or less give one empty result; primes come back alone
        stim_rows.insert(stim_rows.size(), '{32'd0,          1'b1, 31'd0, 1'b1});
        stim_rows.insert(stim_rows.size(), '{32'd1,          1'b1, 31'd0, 1'b1});
        stim_rows.insert(stim_rows.size(), '{32'hFFFF_FFFF,  1'b1, 31'd0, 1'b1});
        stim_rows.insert(stim_rows.size(), '{32'h8000_0000,  1'b1, 31'd0, 1'b1});
        stim_rows.insert(stim_rows.size(), '{32'hFFFF_FFFB,  1'b1, 31'd0, 1'b1});
        stim_rows.insert(stim_rows.size(), '{32'd2,          1'b1, 31'd2, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd3,          1'b1, 31'd3, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd5,          1'b1, 31'd5, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd7,          1'b1, 31'd7, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd97,         1'b1, 31'd97, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd4,          1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd6,          1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd25,         1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd35,         1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd49,         1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd194,        1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd30030,      1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd360360,     1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd1018081,    1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd1022117,    1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd1073741824, 1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd1162261467, 1'b0, 31'd0, 1'b0});
        stim_rows.insert(stim_rows.size(), '{32'd2147483646, 1'b0, 31'd0, 1'b0});
        // largest positive number is prime and takes the full wheel
        stim_rows.insert(stim_rows.size(), '{32'h7FFF_FFFF,  1'b1, 31'h7FFF_FFFF, 1'b0});

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
            send_number(stim_rows[i].number, stim_rows[i].typed,
                        stim_rows[i].factor, stim_rows[i].empty_res);
        directed_cnt = sent_cnt;

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // products of small primes, often with high multiplicity
                prod = 1;
                nf   = $urandom_range(1, 12);
                for (int j = 0; j < nf; j++)
                begin
                    p   = prime_list[$urandom_range(0, 19)];
                    rep = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
                    repeat (rep)
                        if (prod * p <= NUM_MAX)
                            prod = prod * p;
                end
                value = prod[NUM_WIDTH-1:0];
            end
            else if (pick < 75)
                value = $urandom_range(2, 65535);
            else if (pick < 85)
                value = $urandom_range(65536, 1 << 20);
            else if (pick < 95)
                value = $urandom | 32'h8000_0000;
            else
                value = $urandom_range(0, 1);

            if (n == 20)
            begin
                // a long factor list, with the receiver going quiet once it is taken
                value = 32'd1073741824;
            end
            if (n == 60)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(negedge clk);
                while (factor_q.size() != 0);
            end
            send_number(value, 1'b0, '0, 1'b0);
            if (n == 20)
                hold_reqs++;
        end
        s_axis_tvalid <= 1'b0;

        while (factor_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("factored %0d numbers (%0d directed, %0d random): %0d results, %0d empty",
                 sent_cnt, directed_cnt, sent_cnt - directed_cnt, result_cnt, empty_cnt);
        $display("longest factor list %0d, long receiver hold-offs %0d, %0d cycles",
                 longest_run, hold_served, cycle_cnt);
        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/pf6kw_pkg.sv
hw/rtl/prime_factorizer_6k_wheel_top.sv
hw/rtl/pf6kw_checker.sv
tb/sv/prime_factorizer_6k_wheel_top_tb.sv
